[rtl/core/drp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package drp_pkg;

   // accumulator width and output field width
   localparam int VALUE_BITS_DEFAULT = 31;
   localparam int OUT_BITS           = 31;

   // character codes
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0] DIGIT_ZERO   = 8'h30;
   localparam logic [7:0] DIGIT_NINE   = 8'h39;
   localparam logic [3:0] RADIX        = 4'd10;

   // field currently filled by a digit run
   typedef enum logic [1:0] {
      FIELD_SOURCE = 2'd0,
      FIELD_DEST   = 2'd1,
      FIELD_AMOUNT = 2'd2,
      FIELD_DONE   = 2'd3
   } field_sel_type;

endpackage : drp_pkg

`default_nettype wire

[rtl/core/drp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// text byte channel
interface drp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface : drp_req_if

// parsed record channel
interface drp_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] source_id;
   logic [30:0] dest_id;
   logic [30:0] amount;
   logic        overflowed;

   modport source (output valid, output source_id, output dest_id, output amount,
                   output overflowed, input ready);
   modport sink   (input valid, input source_id, input dest_id, input amount,
                   input overflowed, output ready);
endinterface : drp_rsp_if

`default_nettype wire

[rtl/core/drp_dec_acc.sv]
`timescale 1ns / 1ps
`default_nettype none

module drp_dec_acc import drp_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic [VALUE_BITS-1:0] acc_value,
   input  logic [3:0]            digit,
   output logic [VALUE_BITS-1:0] next_value,
   output logic                  saturate
);

   localparam int WIDE_BITS = VALUE_BITS + 4;

   logic [WIDE_BITS-1:0] wide_sum;

   // acc * 10 + digit, never exceeds 16 * 2^VALUE_BITS
   assign wide_sum = WIDE_BITS'(acc_value) * WIDE_BITS'(RADIX) + WIDE_BITS'(digit);

   // any bit above the accumulator width means the result passed the maximum
   assign saturate   = |wide_sum[WIDE_BITS-1:VALUE_BITS];
   assign next_value = saturate ? {VALUE_BITS{1'b1}} : wide_sum[VALUE_BITS-1:0];

endmodule : drp_dec_acc

`default_nettype wire

[rtl/core/decimal_record_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  payload
// req_bus   in         text_byte (8 bits, ASCII)
// rsp_bus   out        source_id, dest_id, amount (31 bits each), overflowed
//
// One byte is taken per clock while req_bus.ready is high; a record follows
// its newline through the byte and result registers. The digit accumulator
// (one multiply by ten and add per byte) is the only loop. Synchronous reset
// clears the line state and both valid flags. A stalled rsp_bus holds the
// byte register, and req_bus.ready drops only when both stages are full.

module decimal_record_parser import drp_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   drp_req_if.sink    req_bus,
   drp_rsp_if.source  rsp_bus
);

   logic                  byte_valid_ff, byte_valid_in;
   logic [7:0]            byte_ff, byte_in;
   logic [VALUE_BITS-1:0] src_ff, src_in;
   logic [VALUE_BITS-1:0] dst_ff, dst_in;
   logic [VALUE_BITS-1:0] amt_ff, amt_in;
   field_sel_type         field_ff, field_in;
   logic                  digits_ff, digits_in;
   logic                  sat_ff, sat_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]   rsp_src_ff, rsp_src_in;
   logic [OUT_BITS-1:0]   rsp_dst_ff, rsp_dst_in;
   logic [OUT_BITS-1:0]   rsp_amt_ff, rsp_amt_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic                  out_free;
   logic                  advance;
   logic                  take;
   logic                  is_newline;
   logic                  is_digit;
   logic [3:0]            digit;
   logic                  emit;
   logic [VALUE_BITS-1:0] cur_acc;
   logic [VALUE_BITS-1:0] acc_next;
   logic                  acc_sat;

   // handshake between the byte stage and the result stage
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign advance       = byte_valid_ff && out_free;
   assign req_bus.ready = !byte_valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   // byte stage
   always_comb begin
      byte_valid_in = byte_valid_ff;
      byte_in       = byte_ff;
      if (take) begin
         byte_valid_in = 1'b1;
         byte_in       = req_bus.text_byte;
      end else if (advance) begin
         byte_valid_in = 1'b0;
      end
   end

   // character classes
   assign is_newline = (byte_ff == NEWLINE_CHAR);
   assign is_digit   = (byte_ff >= DIGIT_ZERO) && (byte_ff <= DIGIT_NINE);
   assign digit      = 4'(byte_ff - DIGIT_ZERO);
   assign emit       = is_newline && (amt_ff != '0);

   // field being filled
   always_comb begin
      unique case (field_ff)
         FIELD_SOURCE: cur_acc = src_ff;
         FIELD_DEST:   cur_acc = dst_ff;
         default:      cur_acc = amt_ff;
      endcase
   end

   drp_dec_acc #(
      .VALUE_BITS (VALUE_BITS)
   ) u_acc (
      .acc_value  (cur_acc),
      .digit      (digit),
      .next_value (acc_next),
      .saturate   (acc_sat)
   );

   // line state update
   always_comb begin
      src_in    = src_ff;
      dst_in    = dst_ff;
      amt_in    = amt_ff;
      field_in  = field_ff;
      digits_in = digits_ff;
      sat_in    = sat_ff;
      if (advance) begin
         priority if (is_newline) begin
            src_in    = '0;
            dst_in    = '0;
            amt_in    = '0;
            field_in  = FIELD_SOURCE;
            digits_in = 1'b0;
            sat_in    = 1'b0;
         end else if (is_digit) begin
            digits_in = 1'b1;
            unique case (field_ff)
               FIELD_SOURCE: src_in = acc_next;
               FIELD_DEST:   dst_in = acc_next;
               FIELD_AMOUNT: amt_in = acc_next;
               default:      ;
            endcase
            if (field_ff != FIELD_DONE) begin
               sat_in = sat_ff || acc_sat;
            end
         end else if (digits_ff) begin
            digits_in = 1'b0;
            if (field_ff != FIELD_DONE) begin
               field_in = field_sel_type'(field_ff + 2'd1);
            end
         end
      end
   end

   // result stage
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_src_in   = rsp_src_ff;
      rsp_dst_in   = rsp_dst_ff;
      rsp_amt_in   = rsp_amt_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
         rsp_src_in   = OUT_BITS'(src_ff);
         rsp_dst_in   = OUT_BITS'(dst_ff);
         rsp_amt_in   = OUT_BITS'(amt_ff);
         rsp_ovf_in   = sat_ff;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         src_ff        <= '0;
         dst_ff        <= '0;
         amt_ff        <= '0;
         field_ff      <= FIELD_SOURCE;
         digits_ff     <= 1'b0;
         sat_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         src_ff        <= src_in;
         dst_ff        <= dst_in;
         amt_ff        <= amt_in;
         field_ff      <= field_in;
         digits_ff     <= digits_in;
         sat_ff        <= sat_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      rsp_src_ff <= rsp_src_in;
      rsp_dst_ff <= rsp_dst_in;
      rsp_amt_ff <= rsp_amt_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.source_id  = rsp_src_ff;
   assign rsp_bus.dest_id    = rsp_dst_ff;
   assign rsp_bus.amount     = rsp_amt_ff;
   assign rsp_bus.overflowed = rsp_ovf_ff;

endmodule : decimal_record_parser

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import drp_pkg::*;

   localparam int ACC_BITS     = VALUE_BITS_DEFAULT;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int SHOW_LIMIT   = 10;

   // separator characters used by the stimulus
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_HIGH  = 8'h80;

   typedef struct packed {
      logic [OUT_BITS-1:0] source_id;
      logic [OUT_BITS-1:0] dest_id;
      logic [OUT_BITS-1:0] amount;
      logic                overflowed;
   } parsed_record_type;

   logic clock;
   logic reset;

   drp_req_if req_bus ();
   drp_rsp_if rsp_bus ();

   decimal_record_parser DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // text bytes waiting to be sent and records waiting to arrive
   logic [7:0]        text_queue[$];
   parsed_record_type expected_records[$];

   // line parsing state mirrored from the block
   logic [63:0]    field_acc[3];
   field_sel_type  field_sel;
   bit             in_number;
   bit             line_saturated;

   int  send_idle_pct;
   int  stall_pct;
   int  hold_requests;
   int  hold_served;
   int  hold_left;
   bit  byte_taken;
   int  bytes_pushed;
   int  bytes_accepted;
   int  errors;
   int  shown;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // clear the current line
   task automatic clear_line();
      field_acc[0]   = '0;
      field_acc[1]   = '0;
      field_acc[2]   = '0;
      field_sel      = FIELD_SOURCE;
      in_number      = 1'b0;
      line_saturated = 1'b0;
   endtask

   // advance the line state by one accepted byte, queue any finished record
   task automatic parse_byte(input logic [7:0] ch);
      logic [63:0]       acc_max;
      logic [63:0]       digit;
      parsed_record_type rec;
      acc_max = (64'd1 << ACC_BITS) - 64'd1;
      if (ch == NEWLINE_CHAR) begin
         if (field_acc[2] != 0) begin
            rec.source_id  = field_acc[0][OUT_BITS-1:0];
            rec.dest_id    = field_acc[1][OUT_BITS-1:0];
            rec.amount     = field_acc[2][OUT_BITS-1:0];
            rec.overflowed = line_saturated;
            expected_records.insert(expected_records.size(), rec);
         end
         clear_line();
      end else if (ch >= DIGIT_ZERO && ch <= DIGIT_NINE) begin
         if (field_sel != FIELD_DONE) begin
            digit = 64'(ch - DIGIT_ZERO);
            if (field_acc[field_sel] > (acc_max - digit) / 64'(RADIX)) begin
               field_acc[field_sel] = acc_max;
               line_saturated       = 1'b1;
            end else begin
               field_acc[field_sel] = field_acc[field_sel] * 64'(RADIX) + digit;
            end
         end
         in_number = 1'b1;
      end else if (in_number) begin
         if (field_sel != FIELD_DONE)
            field_sel = field_sel_type'(field_sel + 2'd1);
         in_number = 1'b0;
      end
   endtask

   task automatic report_error(input string msg);
      errors++;
      if (shown < SHOW_LIMIT) begin
         shown++;
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   // byte transactions and record transactions are taken at the rising edge
   always @(posedge clock) begin
      parsed_record_type got;
      parsed_record_type want;
      byte_taken = 1'b0;
      if (reset) begin
         clear_line();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            byte_taken = 1'b1;
            bytes_accepted++;
            parse_byte(req_bus.text_byte);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.source_id  = rsp_bus.source_id;
            got.dest_id    = rsp_bus.dest_id;
            got.amount     = rsp_bus.amount;
            got.overflowed = rsp_bus.overflowed;
            if (expected_records.size() == 0) begin
               report_error($sformatf("unexpected record src=%0d dst=%0d amt=%0d ovf=%0b",
                  got.source_id, got.dest_id, got.amount, got.overflowed));
            end else begin
               want = expected_records.pop_front();
               if (got.source_id !== want.source_id || got.dest_id !== want.dest_id ||
                   got.amount !== want.amount || got.overflowed !== want.overflowed)
                  report_error($sformatf({"record mismatch: ",
                     "expected src=%0d dst=%0d amt=%0d ovf=%0b, ",
                     "got src=%0d dst=%0d amt=%0d ovf=%0b"},
                     want.source_id, want.dest_id, want.amount, want.overflowed,
                     got.source_id, got.dest_id, got.amount, got.overflowed));
            end
         end
      end
   end

   // byte driver, fed from the text queue
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || byte_taken) begin
         if (text_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_bus.valid     <= 1'b1;
            req_bus.text_byte <= text_queue.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // record receiver, with random stalls and an occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic push_byte(input logic [7:0] ch);
      text_queue.insert(text_queue.size(), ch);
      bytes_pushed++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_byte(s[i]);
   endtask

   // one run of separators, mostly a single one
   task automatic push_separators();
      int count;
      count = ($urandom_range(3) == 0) ? $urandom_range(2, 4) : 1;
      repeat (count) begin
         case ($urandom_range(7))
            0:       push_byte(CH_COMMA);
            1:       push_byte(CH_SPACE);
            2:       push_byte(CH_TAB);
            3:       push_byte(CH_CR);
            4:       push_byte(CH_NUL);
            5:       push_byte(CH_HIGH | 8'($urandom_range(127)));
            6:       push_byte(CH_SEMI);
            default: push_byte(8'($urandom_range(255)));
         endcase
      end
   endtask

   // one decimal field: small, full 32-bit, near the maximum, overflowing, padded or zero
   task automatic push_field();
      logic [63:0] near_max;
      case ($urandom_range(5))
         0: push_text($sformatf("%0d", $urandom_range(99)));
         1: push_text($sformatf("%0d", $urandom()));
         2: begin
            near_max = 64'd2147483640 + 64'($urandom_range(15));
            push_text($sformatf("%0d", near_max));
         end
         3: repeat ($urandom_range(11, 20)) push_byte(DIGIT_ZERO + 8'($urandom_range(9)));
         4: push_text($sformatf("000%0d", $urandom_range(999)));
         default: push_byte(DIGIT_ZERO);
      endcase
   endtask

   // random lines, mostly well formed, until both byte and line targets are met
   task automatic push_random_text(input int n_bytes, input int n_lines);
      int start_bytes;
      int full_lines;
      int n_fields;
      start_bytes = bytes_pushed;
      full_lines  = 0;
      while (bytes_pushed - start_bytes < n_bytes || full_lines < n_lines) begin
         if ($urandom_range(9) == 0) begin
            // noise over the whole byte range
            repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(255)));
         end else begin
            n_fields = ($urandom_range(9) < 7) ? 3 : $urandom_range(5);
            if ($urandom_range(7) == 0)
               push_separators();
            for (int f = 0; f < n_fields; f++) begin
               push_field();
               if (f < n_fields - 1)
                  push_separators();
            end
            if ($urandom_range(5) == 0)
               push_separators();
            if ($urandom_range(3) == 0)
               push_byte(CH_CR);
            // now and then a line runs into the next one
            if ($urandom_range(24) != 0)
               push_byte(NEWLINE_CHAR);
            if (n_fields >= 3)
               full_lines++;
         end
      end
   endtask

   // reset, then the traffic phases
   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.text_byte = '0;
      rsp_bus.ready     = 1'b0;
      send_idle_pct     = 0;
      stall_pct         = 0;
      hold_requests     = 0;
      hold_served       = 0;
      hold_left         = 0;
      bytes_pushed      = 0;
      bytes_accepted    = 0;
      errors            = 0;
      shown             = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < 5; phase++) begin
         @(posedge clock);
         case (phase)
            1:       begin send_idle_pct = 79; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 79; end
            3:       begin send_idle_pct = 25; stall_pct = 25; end
            default: begin send_idle_pct = 0;  stall_pct = 0;  end
         endcase
         if (phase == 0) begin
            // exact maximum, odd separators, saturated field, extra field
            push_text("2147483647");
            push_byte(CH_NUL);
            push_byte(CH_CR);
            push_byte(8'hFF);
            push_text(",99999999999");
            push_byte(CH_HIGH);
            push_text("1;2");
            push_byte(NEWLINE_CHAR);
            // zero weight, empty line, plain record
            push_text("0,0,0");
            push_byte(NEWLINE_CHAR);
            push_byte(NEWLINE_CHAR);
            push_text("5,6,7");
            push_byte(NEWLINE_CHAR);
         end
         if (phase == 4)
            hold_requests++;
         push_random_text(160, 10);
         wait (text_queue.size() == 0);
      end

      // last line without a newline is never emitted
      push_text("12,34,56");
      wait (bytes_accepted == bytes_pushed);
      wait (expected_records.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // run limit
   initial begin
      #1000000;
      $display("FAILURE");
      $finish;
   end

endmodule : testbench
